// File: rtl/bounded_deque_assert.svh
// Assertion macros shared by the bounded deque RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef BOUNDED_DEQUE_ASSERT_SVH
`define BOUNDED_DEQUE_ASSERT_SVH

// Overlapping implication, checked at every rising clock edge out of reset.
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bounded_deque assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bounded_deque assertion failed");

`endif

// File: rtl/bdq_pkg.sv
// Shared types and constants of the bounded deque.
// Used by the storage cell and the top level; depends on nothing.
package bdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned CapW  = 5;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned CapReset = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_NOP        = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_REAR  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_REAR   = 3'd4
  } cmd_e;

  // Operation broadcast to every cell of the row in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_IN,
    OP_SHIFT_OUT,
    OP_APPEND,
    OP_TRIM
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] word;
  } cell_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] data;
  } link_t;

endpackage

// File: rtl/bdq_cell.sv
// One storage cell of the deque row: a word and its valid bit.
// Depends on bdq_pkg; instantiated DEPTH times by bounded_deque.
module bdq_cell import bdq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  link_t      front_i,  // stored state of the neighbor toward the front
  input  link_t      rear_i,   // stored state of the neighbor toward the rear
  output link_t      state_o,
  output link_t      next_o
);

  logic             valid_q, valid_d;
  logic [WordW-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (ctrl_i.op)
      OP_SHIFT_IN: begin
        valid_d = front_i.valid;
        data_d  = front_i.data;
      end
      OP_SHIFT_OUT: begin
        valid_d = rear_i.valid;
        data_d  = rear_i.data;
      end
      OP_APPEND: begin
        // Only the first free cell behind the live run takes the word.
        if (!valid_q && front_i.valid) begin
          valid_d = 1'b1;
          data_d  = ctrl_i.word;
        end
      end
      OP_TRIM: begin
        if (valid_q && !rear_i.valid) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        valid_d = valid_q;
        data_d  = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign state_o = '{valid: valid_q, data: data_q};
  assign next_o  = '{valid: valid_d, data: data_d};

endmodule

// File: rtl/bounded_deque.sv
// Bounded double-ended queue of signed 32-bit words built as a row of cells.
// Depends on bdq_pkg, bdq_cell and bounded_deque_assert.svh.

// The deque takes one command item per clock cycle while results are taken
// on the master side, and presents each result item there in the cycle after
// acceptance; a new item is taken in the cycle the previous result is handed
// off. The live entries always sit compacted at the front of a row of DEPTH
// cells: push front and pop front shift the whole row by one cell, while push
// rear and pop rear touch only the cell at the end of the live run. The row's
// valid bits clear at reset, so no clearing pass is needed.
module bounded_deque import bdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CapW-1:0]  cfg_wdata_i,     // capacity
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [WordW-1:0] s_axis_tdata,    // [31:0] push_value
  input  logic [CmdW-1:0]  s_axis_tuser,    // [2:0] cmd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [3*WordW-1:0] m_axis_tdata,  // [31:0] pop_value, [63:32] front_value,
                                            // [95:64] rear_value
  output logic [2:0]       m_axis_tuser     // [0] ok, [1] is_empty, [2] is_full
);

  `include "bounded_deque_assert.svh"

  localparam logic [WordW-1:0] EmptyWord = '1;

  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] eff_cap, count_ext, count_d_ext;

  logic accept;
  logic room, live;
  logic ok;
  logic [WordW-1:0] pop_word;
  cell_ctrl_t ctrl;

  link_t cell_q [DEPTH];
  link_t cell_d [DEPTH];
  link_t front_link [DEPTH];
  link_t rear_link [DEPTH];
  logic [DEPTH-1:0] valid_q_vec;
  logic [DEPTH-1:0] last_q, last_d;
  logic [WordW-1:0] rear_q, rear_d;

  logic             out_valid_q;
  logic             out_ok_q, out_empty_q, out_full_q;
  logic [WordW-1:0] out_pop_q, out_front_q, out_rear_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Capacity above DEPTH saturates at DEPTH.
  assign eff_cap = (CmpW'(cap_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(cap_q);
  assign count_ext = CmpW'(count_q);
  assign room = count_ext < eff_cap;
  assign live = count_q != '0;

  always_comb begin
    ok       = 1'b1;
    ctrl.op  = OP_HOLD;
    ctrl.word = s_axis_tdata;
    count_d  = count_q;
    pop_word = EmptyWord;
    unique case (s_axis_tuser) inside
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        ok = room;
        if (room) begin
          ctrl.op = (s_axis_tuser == CMD_PUSH_FRONT) ? OP_SHIFT_IN : OP_APPEND;
          count_d = count_q + CntW'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        ok = live;
        if (live) begin
          ctrl.op  = (s_axis_tuser == CMD_POP_FRONT) ? OP_SHIFT_OUT : OP_TRIM;
          pop_word = (s_axis_tuser == CMD_POP_FRONT) ? cell_q[0].data : rear_q;
          count_d  = count_q - CntW'(1);
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
    if (!accept) begin
      ctrl.op = OP_HOLD;
      count_d = count_q;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign front_link[i] = '{valid: 1'b1, data: s_axis_tdata};
    end else begin : g_body
      assign front_link[i] = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rear_link[i] = '{valid: 1'b0, data: '0};
      assign last_q[i] = cell_q[i].valid;
      assign last_d[i] = cell_d[i].valid;
    end else begin : g_mid
      assign rear_link[i] = cell_q[i+1];
      assign last_q[i] = cell_q[i].valid && !cell_q[i+1].valid;
      assign last_d[i] = cell_d[i].valid && !cell_d[i+1].valid;
    end
    assign valid_q_vec[i] = cell_q[i].valid;

    bdq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .front_i (front_link[i]),
      .rear_i  (rear_link[i]),
      .state_o (cell_q[i]),
      .next_o  (cell_d[i])
    );
  end

  // At most one cell is flagged as the end of the live run, so an OR selects it.
  always_comb begin
    rear_q = '0;
    rear_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_q = rear_q | (cell_q[i].data & {WordW{last_q[i]}});
      rear_d = rear_d | (cell_d[i].data & {WordW{last_d[i]}});
    end
  end

  assign count_d_ext = CmpW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapW'(CapReset);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_ok_q    <= ok;
      out_pop_q   <= pop_word;
      out_front_q <= (count_d != '0) ? cell_d[0].data : EmptyWord;
      out_rear_q  <= (count_d != '0) ? rear_d : EmptyWord;
      out_empty_q <= count_d == '0;
      out_full_q  <= count_d_ext >= eff_cap;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rear_q, out_front_q, out_pop_q};
  assign m_axis_tuser  = {out_full_q, out_empty_q, out_ok_q};

  `BDQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, CmpW'(count_q) <= CmpW'(DEPTH))
  `BDQ_ASSERT_IMP(a_valid_matches_count, clk_i, rst_ni, 1'b1,
                  CntW'($countones(valid_q_vec)) == count_q)
  `BDQ_ASSERT_IMP(a_valid_compact, clk_i, rst_ni, 1'b1, $onehot0(last_q) && $onehot0(last_d))
  `BDQ_ASSERT_NXT(a_refused_holds, clk_i, rst_ni, accept && !ok,
                  count_q == $past(count_q) && valid_q_vec == $past(valid_q_vec))
  `BDQ_ASSERT_IMP(a_empty_words, clk_i, rst_ni, out_valid_q && out_empty_q,
                  out_front_q == EmptyWord && out_rear_q == EmptyWord)

endmodule
